>>> design/cfos_pkg.sv
// Package: command codes, sequencer states, payload types and constants of the command FIFO.
`timescale 1ns / 1ps
`default_nettype none
package cfos_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 128;
  localparam int CMD_W = 3;
  localparam int WORD_W = 32;
  localparam int OPC_W = 8;
  localparam int FILL_W = 8;
  localparam logic [OPC_W-1:0] EMPTY_OPCODE = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_DISCARD = 3'd2,
    CMD_SEARCH  = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEARCH,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] push_word;
    logic [OPC_W-1:0]  search_opcode;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic [WORD_W-1:0] popped_word;
    logic              found;
    logic [OPC_W-1:0]  front_opcode;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
  } out_word_t;

endpackage
`default_nettype wire

>>> design/cfos_if.sv
// Interfaces: valid/ready channels for command words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface cfos_in_if;
  import cfos_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfos_out_if;
  import cfos_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/command_fifo_with_opcode_search.sv
// Command FIFO with opcode search.
//
// in_chan carries one command word (cmd, push_word, search_opcode); out_chan returns
// exactly one result word per command, in order, valid/ready handshakes on both.
// Entries sit in a single-port-read, single-port-write memory of QUEUE_DEPTH words;
// the oldest word is cached in a register so results need no extra read.
// Steps per command, from accept to result register loaded:
//   push, clear, unknown codes: the done state, which loads the output register
//   pop, discard: a fetch state, in which one registered read refills the cached
//   oldest word, then the done state; the fetch is skipped when at most one word was held
//   search: the memory read port walks one entry a cycle from oldest to newest
//   and stops at the first opcode match or after the last held word.
// in_chan.ready is high only while the sequencer is idle. A finished result moves
// into the output register as soon as it is free, so the next command is taken
// while a result waits; when out_chan stalls, the block holds the following result
// and takes no more commands until the output register drains.
// Reset (rst_n low, synchronous) empties the queue, clears pointers and count and
// drops any pending result; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module command_fifo_with_opcode_search #(
  parameter int QUEUE_DEPTH = cfos_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  cfos_in_if.sink    in_chan,
  cfos_out_if.source out_chan
);
  import cfos_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];

  seq_state_t        state_r, state_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [PW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]     scan_left_r, scan_left_nxt;
  logic              pend_r, pend_nxt;
  logic [OPC_W-1:0]  want_r, want_nxt;
  logic              acc_r, acc_nxt;
  logic [WORD_W-1:0] popped_r, popped_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;
  logic [WORD_W-1:0] rd_data_r;

  logic [PW-1:0] rd_addr;
  logic          wr_en;
  logic [PW-1:0] rp_inc, wp_inc, scan_inc;
  logic          in_fire, hit, out_free;
  cmd_code_t     cmd;

  assign rp_inc   = (rp_r == LAST_SLOT) ? '0 : rp_r + 1'b1;
  assign wp_inc   = (wp_r == LAST_SLOT) ? '0 : wp_r + 1'b1;
  assign scan_inc = (scan_idx_r == LAST_SLOT) ? '0 : scan_idx_r + 1'b1;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cmd      = cmd_code_t'(in_chan.data.cmd);
  assign hit      = pend_r && (rd_data_r[OPC_W-1:0] == want_r);
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((cmd == CMD_POP || cmd == CMD_DISCARD) && count_r > CW'(1)) begin
            state_nxt = ST_FETCH;
          end else if (cmd == CMD_SEARCH) begin
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FETCH:  state_nxt = ST_DONE;
      ST_SEARCH: begin
        if (hit || (scan_left_r == '0 && !pend_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    scan_idx_nxt  = scan_idx_r;
    scan_left_nxt = scan_left_r;
    pend_nxt      = 1'b0;
    want_nxt      = want_r;
    acc_nxt       = acc_r;
    popped_nxt    = popped_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    rd_addr       = rp_inc;
    wr_en         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt      = 1'b0;
          found_nxt    = 1'b0;
          popped_nxt   = (count_r == '0) ? '0 : front_r;
          want_nxt     = in_chan.data.search_opcode;
          scan_idx_nxt = rp_r;
          scan_left_nxt = count_r;
          case (cmd) inside
            CMD_PUSH: begin
              if (count_r < FULL_COUNT) begin
                wr_en     = 1'b1;
                wp_nxt    = wp_inc;
                count_nxt = count_r + 1'b1;
                acc_nxt   = 1'b1;
                if (count_r == '0) begin
                  front_nxt = in_chan.data.push_word;
                end
              end
            end
            CMD_POP, CMD_DISCARD: begin
              if (count_r != '0) begin
                rp_nxt    = rp_inc;
                count_nxt = count_r - 1'b1;
                acc_nxt   = 1'b1;
              end
            end
            CMD_CLEAR: begin
              wp_nxt    = '0;
              rp_nxt    = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        front_nxt = rd_data_r;
      end
      ST_SEARCH: begin
        rd_addr = scan_idx_r;
        if (hit) begin
          found_nxt = 1'b1;
        end else if (scan_left_r != '0) begin
          pend_nxt      = 1'b1;
          scan_idx_nxt  = scan_inc;
          scan_left_nxt = scan_left_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.accepted     = acc_r;
          out_data_nxt.popped_word  = popped_r;
          out_data_nxt.found        = found_r;
          out_data_nxt.front_opcode = (count_r == '0) ? EMPTY_OPCODE : front_r[OPC_W-1:0];
          out_data_nxt.fill_count   = FILL_W'(count_r);
          out_data_nxt.is_empty     = (count_r == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= in_chan.data.push_word;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      count_r     <= '0;
      scan_left_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      count_r     <= count_nxt;
      scan_left_r <= scan_left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    scan_idx_r <= scan_idx_nxt;
    want_r     <= want_nxt;
    acc_r      <= acc_nxt;
    popped_r   <= popped_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_COUNT) |-> (rp_r == wp_r))
    else $error("pointers disagree with empty or full count");

  a_pend_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SEARCH))
    else $error("scan read pending outside search");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_PUSH && count_r < FULL_COUNT) |=>
      (count_r == $past(count_r) + 1'b1))
    else $error("accepted push did not grow the queue");
`endif

endmodule
`default_nettype wire
